// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the substring search block.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define SFM_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define SFM_ASSERT(lbl, clk, rstn, prop)
`define SFM_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/sfm_pkg.sv =====
// Package for the substring search block: sizes, mode and op codes, item type.
// No dependencies.
`timescale 1ns / 1ps
package sfm_pkg;

    localparam int CHAR_BITS   = 16;
    localparam int MAX_PATTERN = 16;
    localparam int MAX_TEXT    = 65536;
    localparam int POS_W       = 16;
    localparam int PCNT_W      = $clog2(MAX_PATTERN + 1);
    localparam int TCNT_W      = $clog2(MAX_TEXT + 1);

    // queue depth is a power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEXT   = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/sfm_front.sv =====
// Front stage: accepts input items, decodes mode, drops undefined modes.
// Depends on sfm_pkg.
`timescale 1ns / 1ps
module sfm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [15:0]                   ch,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sfm_pkg::item_t                item
);
    import sfm_pkg::*;

    logic  hold_valid_reg, hold_valid_next;
    item_t hold_item_reg, hold_item_next;
    logic  take;
    logic  known;
    op_t   op_dec;

    assign in_ready  = !hold_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = hold_valid_reg;
    assign item      = hold_item_reg;

    always_comb
    begin
        known  = 1'b1;
        op_dec = OP_TEXT;
        case (mode)
            MODE_CLEAR:  op_dec = OP_CLEAR;
            MODE_APPEND: op_dec = OP_APPEND;
            MODE_TEXT:   op_dec = OP_TEXT;
            default:     known  = 1'b0;
        endcase
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (take)
        begin
            hold_valid_next     = known;
            hold_item_next.op   = op_dec;
            hold_item_next.ch   = ch[CHAR_BITS-1:0];
            hold_item_next.last = last && (op_dec == OP_TEXT);
        end
        else if (out_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

endmodule

// ===== rtl/sfm_queue.sv =====
// Short FIFO of decoded items between the front and back stages.
// Depends on sfm_pkg.
`timescale 1ns / 1ps
module sfm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfm_pkg::item_t     in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sfm_pkg::item_t     out_item,
    output sfm_pkg::q_stat_t   stat
);
    import sfm_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign in_ready   = !stat.full;
    assign out_valid  = !stat.empty;
    assign out_item   = mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== rtl/sfm_back.sv =====
// Back stage: pattern shift register, text window, parallel compare, result.
// Depends on sfm_pkg.
`timescale 1ns / 1ps
module sfm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sfm_pkg::item_t      in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [15:0]         position,
    output logic                text_too_long,
    output logic                pattern_too_long
);
    import sfm_pkg::*;

    // pattern and window both keep the newest character at index 0
    logic [CHAR_BITS-1:0] pat_reg [MAX_PATTERN];
    logic [CHAR_BITS-1:0] win_reg [MAX_PATTERN];
    logic [CHAR_BITS-1:0] win_shift [MAX_PATTERN];

    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic              povf_reg, povf_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic              tovf_reg, tovf_next;
    logic              seen_reg, seen_next;
    logic [POS_W-1:0]  start_reg, start_next;

    logic              res_valid_reg, res_valid_next;
    logic              res_found_reg, res_found_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic              res_tovf_reg, res_tovf_next;
    logic              res_povf_reg, res_povf_next;

    logic                  take;
    logic                  shift_pat, shift_win;
    logic [TCNT_W-1:0]     tcnt_inc;
    logic [TCNT_W-1:0]     start_full;
    logic [MAX_PATTERN-1:0] hit;
    logic                  len_ok;

    assign in_ready = !res_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign tcnt_inc = tcnt_reg + 1'b1;
    assign len_ok   = ({{(TCNT_W-PCNT_W){1'b0}}, pcnt_reg} <= tcnt_inc);
    assign start_full = tcnt_inc - {{(TCNT_W-PCNT_W){1'b0}}, pcnt_reg};

    always_comb
    begin
        win_shift[0] = in_item.ch;
        for (int i = 1; i < MAX_PATTERN; i++)
            win_shift[i] = win_reg[i-1];
        for (int k = 0; k < MAX_PATTERN; k++)
            hit[k] = (PCNT_W'(k) >= pcnt_reg) || (win_shift[k] == pat_reg[k]);
    end

    always_comb
    begin
        pcnt_next      = pcnt_reg;
        povf_next      = povf_reg;
        tcnt_next      = tcnt_reg;
        tovf_next      = tovf_reg;
        seen_next      = seen_reg;
        start_next     = start_reg;
        shift_pat      = 1'b0;
        shift_win      = 1'b0;
        res_valid_next = out_ready ? 1'b0 : res_valid_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_tovf_next  = res_tovf_reg;
        res_povf_next  = res_povf_reg;
        if (take)
        begin
            case (in_item.op)
                OP_CLEAR:
                begin
                    pcnt_next  = '0;
                    povf_next  = 1'b0;
                    tcnt_next  = '0;
                    tovf_next  = 1'b0;
                    seen_next  = 1'b0;
                    start_next = '0;
                end
                OP_APPEND:
                begin
                    if (pcnt_reg < PCNT_W'(MAX_PATTERN))
                    begin
                        shift_pat = 1'b1;
                        pcnt_next = pcnt_reg + 1'b1;
                    end
                    else
                    begin
                        povf_next = 1'b1;
                    end
                end
                OP_TEXT:
                begin
                    if (tcnt_reg >= TCNT_W'(MAX_TEXT))
                    begin
                        tovf_next = 1'b1;
                    end
                    else
                    begin
                        shift_win = 1'b1;
                        tcnt_next = tcnt_inc;
                        if (!seen_reg)
                        begin
                            if (pcnt_reg == '0)
                            begin
                                seen_next  = 1'b1;
                                start_next = '0;
                            end
                            else if (len_ok && (&hit))
                            begin
                                seen_next  = 1'b1;
                                start_next = start_full[POS_W-1:0];
                            end
                        end
                    end
                    if (in_item.last)
                    begin
                        res_valid_next = 1'b1;
                        res_found_next = seen_next;
                        res_pos_next   = seen_next ? start_next : '0;
                        res_tovf_next  = tovf_next;
                        res_povf_next  = povf_reg;
                        tcnt_next      = '0;
                        tovf_next      = 1'b0;
                        seen_next      = 1'b0;
                        start_next     = '0;
                    end
                end
                default:
                begin
                    pcnt_next = pcnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg      <= '0;
            povf_reg      <= 1'b0;
            tcnt_reg      <= '0;
            tovf_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pcnt_reg      <= pcnt_next;
            povf_reg      <= povf_next;
            tcnt_reg      <= tcnt_next;
            tovf_reg      <= tovf_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // only positions below the live counts are ever compared
    always_ff @(posedge clk)
    begin
        if (shift_pat)
        begin
            pat_reg[0] <= in_item.ch;
            for (int i = 1; i < MAX_PATTERN; i++)
                pat_reg[i] <= pat_reg[i-1];
        end
        if (shift_win)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                win_reg[i] <= win_shift[i];
        end
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_tovf_reg  <= res_tovf_next;
        res_povf_reg  <= res_povf_next;
    end

    assign out_valid        = res_valid_reg;
    assign found            = res_found_reg;
    assign position         = res_pos_reg;
    assign text_too_long    = res_tovf_reg;
    assign pattern_too_long = res_povf_reg;

endmodule

// ===== rtl/substring_first_match.sv =====
// Streaming first-occurrence search of a stored pattern in a text of wide
// characters. Sustains one item per cycle while no result waits on the output:
// a decode register feeds a two-entry queue, and the back stage compares the
// full 16-character window against the pattern in parallel for every text
// character. A last text item passes the decode register and the queue, and its
// result holds in the output register; while it waits, the back stage stalls
// and the queue and decode register absorb three more items.
// Depends on sfm_pkg, sfm_front, sfm_queue, sfm_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module substring_first_match (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] ch,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] position,
    output logic        text_too_long,
    output logic        pattern_too_long
);
    import sfm_pkg::*;

    logic    front_valid, front_ready;
    item_t   front_item;
    logic    q_valid, q_ready;
    item_t   q_item;
    q_stat_t q_stat;

    sfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .ch        (ch),
        .last      (last),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .item      (front_item)
    );

    sfm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item),
        .stat      (q_stat)
    );

    sfm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (q_valid),
        .in_ready         (q_ready),
        .in_item          (q_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .position         (position),
        .text_too_long    (text_too_long),
        .pattern_too_long (pattern_too_long)
    );

    `SFM_ASSERT(a_pos_zero_when_missing, clk, rst_n, (out_valid && !found) |-> (position == '0))
    `SFM_ASSERT(a_back_waits_for_output, clk, rst_n, (q_valid && q_ready) |-> (!out_valid || out_ready))
    `SFM_ASSERT(a_front_holds_on_stall, clk, rst_n, (front_valid && !front_ready) |=> front_valid)
    `SFM_ASSERT_NEVER(a_queue_full_and_empty, clk, rst_n, q_stat.full && q_stat.empty)

endmodule
